FILE: src/fcps_pkg.sv
// ----------------------------------------------------------------------------
// fcps_pkg
// shared types and constants for the filled circle pixel stream
// ----------------------------------------------------------------------------
package fcps_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    // field widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 9;
    localparam int RAD_W   = 9;
    localparam int COLOR_W = 16;
    localparam int RR_W    = 2 * RAD_W;
    localparam int KIND_W  = 2;

    // packed request data: center_x, center_y, radius, fill_color from bit 0 up
    localparam int S_DATA_USED = COL_W + ROW_W + RAD_W + COLOR_W;
    localparam int S_DATA_W    = ((S_DATA_USED + 7) / 8) * 8;

    localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 16'hFFFF;

    // request operation
    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // bus word kind
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA   = 2'd0,
        KIND_COLSET = 2'd1,
        KIND_ROWSET = 2'd2,
        KIND_RAMWR  = 2'd3
    } kind_t;

    // position in the word sequence of one circle
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_COLSET,
        PH_COL_LH,
        PH_COL_LL,
        PH_COL_RH,
        PH_COL_RL,
        PH_ROWSET,
        PH_ROW_TH,
        PH_ROW_TL,
        PH_ROW_BH,
        PH_ROW_BL,
        PH_RAMWR,
        PH_PIXEL
    } phase_t;

endpackage

FILE: src/fcps_span_clamp.sv
// ----------------------------------------------------------------------------
// fcps_span_clamp
// clamps center-radius..center+radius into 0..max_pos, low bound never above high
// ----------------------------------------------------------------------------
module fcps_span_clamp (
    input  logic [fcps_pkg::ROW_W-1:0] center,
    input  logic [fcps_pkg::RAD_W-1:0] radius,
    input  logic [fcps_pkg::ROW_W-1:0] max_pos,
    output logic [fcps_pkg::ROW_W-1:0] lo,
    output logic [fcps_pkg::ROW_W-1:0] hi
);
    import fcps_pkg::*;

    localparam int SW = ROW_W + 3;

    logic signed [SW-1:0] lo_raw;
    logic signed [SW-1:0] hi_raw;
    logic signed [SW-1:0] max_s;
    logic [ROW_W-1:0]     lo_c;
    logic [ROW_W-1:0]     hi_c;

    assign max_s  = $signed({{(SW-ROW_W){1'b0}}, max_pos});
    assign lo_raw = $signed({{(SW-ROW_W){1'b0}}, center})
                  - $signed({{(SW-RAD_W){1'b0}}, radius});
    assign hi_raw = $signed({{(SW-ROW_W){1'b0}}, center})
                  + $signed({{(SW-RAD_W){1'b0}}, radius});

    always_comb begin
        priority if (lo_raw < 0) begin
            lo_c = '0;
        end else if (lo_raw > max_s) begin
            lo_c = max_pos;
        end else begin
            lo_c = lo_raw[ROW_W-1:0];
        end

        priority if (hi_raw < 0) begin
            hi_c = '0;
        end else if (hi_raw > max_s) begin
            hi_c = max_pos;
        end else begin
            hi_c = hi_raw[ROW_W-1:0];
        end

        hi = hi_c;
        lo = (lo_c > hi_c) ? hi_c : lo_c;
    end

endmodule

FILE: src/fcps_pixel_test.sv
// ----------------------------------------------------------------------------
// fcps_pixel_test
// inside test dx*dx + dy*dy < r*r for the current scan position
// ----------------------------------------------------------------------------
module fcps_pixel_test (
    input  logic [fcps_pkg::COL_W-1:0] scan_col,
    input  logic [fcps_pkg::ROW_W-1:0] scan_row,
    input  logic [fcps_pkg::COL_W-1:0] center_x,
    input  logic [fcps_pkg::ROW_W-1:0] center_y,
    input  logic [fcps_pkg::RR_W-1:0]  radius_sq,
    output logic                       in_circle
);
    import fcps_pkg::*;

    localparam int SUM_W = 2 * ROW_W + 1;

    logic [COL_W-1:0]   abs_dx;
    logic [ROW_W-1:0]   abs_dy;
    logic [2*COL_W-1:0] dx_sq;
    logic [2*ROW_W-1:0] dy_sq;
    logic [SUM_W-1:0]   dist_sq;

    // magnitudes first, so the squares are plain unsigned products
    assign abs_dx    = (scan_col >= center_x) ? (scan_col - center_x) : (center_x - scan_col);
    assign abs_dy    = (scan_row >= center_y) ? (scan_row - center_y) : (center_y - scan_row);
    assign dx_sq     = (2*COL_W)'(abs_dx) * (2*COL_W)'(abs_dx);
    assign dy_sq     = (2*ROW_W)'(abs_dy) * (2*ROW_W)'(abs_dy);
    assign dist_sq   = SUM_W'(dx_sq) + SUM_W'(dy_sq);
    assign in_circle = dist_sq < SUM_W'(radius_sq);

endmodule

FILE: src/filled_circle_pixel_stream.sv
// ----------------------------------------------------------------------------
// filled_circle_pixel_stream
// turns circle requests into a display-bus word stream: window setup
// commands and address bytes, then one color per window pixel
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tuser operation, s_tdata circle
// m_*       out        m_tvalid/m_tready  m_tuser word kind, m_tdata value,
//                                         m_tlast final pixel word
// cfg_*     in         cfg_wr_en          cfg_wr_data background color
//
// each request is held in the input register, where the word logic works on
// it, and its word is written into the result register, which drives m_*;
// one request is taken per cycle when m_tready stays high, and the pixel
// test is combinational (two narrow squares, an add and a compare)
// start requests and advance requests while idle give no word
// reset clears the handshake valids and the sequencer; background color
// returns to 0xffff
// m_tready low holds the result register and, through it, the input side
// ----------------------------------------------------------------------------
module filled_circle_pixel_stream (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center_x[7:0], center_y[16:8], radius[25:17], fill_color[41:26], zero fill
    input  logic [fcps_pkg::S_DATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    // word channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // word_value[15:0]
    output logic [fcps_pkg::COLOR_W-1:0]       m_tdata,
    // word_kind[1:0]
    output logic [fcps_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast,
    // background color register
    input  logic                               cfg_wr_en,
    input  logic [fcps_pkg::COLOR_W-1:0]       cfg_wr_data
);
    import fcps_pkg::*;

    localparam logic [ROW_W-1:0] COL_MAX = ROW_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_HEIGHT - 1);

    // background color register
    logic [COLOR_W-1:0] bg_color_reg;

    // input register stage
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [COL_W-1:0]   in_cx_reg;
    logic [ROW_W-1:0]   in_cy_reg;
    logic [RAD_W-1:0]   in_radius_reg;
    logic [COLOR_W-1:0] in_color_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [COL_W-1:0]   left_col_reg, left_col_next;
    logic [COL_W-1:0]   right_col_reg, right_col_next;
    logic [ROW_W-1:0]   top_row_reg, top_row_next;
    logic [ROW_W-1:0]   bottom_row_reg, bottom_row_next;
    logic [COL_W-1:0]   held_cx_reg, held_cx_next;
    logic [ROW_W-1:0]   held_cy_reg, held_cy_next;
    logic [RR_W-1:0]    held_rr_reg, held_rr_next;
    logic [COLOR_W-1:0] held_color_reg, held_color_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg;
    logic [COLOR_W-1:0] m_value_reg;
    logic               m_last_reg;

    // word logic
    logic               out_free;
    logic               fire;
    logic               is_start;
    logic               produce;
    logic               in_circle;
    logic               row_end;
    logic               col_end;
    kind_t              word_kind;
    logic [COLOR_W-1:0] word_value;
    logic               word_last;
    logic [ROW_W-1:0]   win_left, win_right, win_top, win_bottom;
    logic [COLOR_W-1:0] left_w, right_w, top_w, bottom_w;

    // result register frees when empty or taken this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign is_start = (in_op_reg == OP_START);
    assign produce  = fire && !is_start && (phase_reg != PH_IDLE);
    assign s_tready = !in_valid_reg || out_free;

    // window of the request in the input register
    fcps_span_clamp u_col_clamp (
        .center  ({1'b0, in_cx_reg}),
        .radius  (in_radius_reg),
        .max_pos (COL_MAX),
        .lo      (win_left),
        .hi      (win_right)
    );

    fcps_span_clamp u_row_clamp (
        .center  (in_cy_reg),
        .radius  (in_radius_reg),
        .max_pos (ROW_MAX),
        .lo      (win_top),
        .hi      (win_bottom)
    );

    fcps_pixel_test u_pixel_test (
        .scan_col  (scan_col_reg),
        .scan_row  (scan_row_reg),
        .center_x  (held_cx_reg),
        .center_y  (held_cy_reg),
        .radius_sq (held_rr_reg),
        .in_circle (in_circle)
    );

    assign row_end = scan_row_reg >= bottom_row_reg;
    assign col_end = scan_col_reg >= right_col_reg;

    // address bytes, high byte first
    assign left_w   = COLOR_W'(left_col_reg);
    assign right_w  = COLOR_W'(right_col_reg);
    assign top_w    = COLOR_W'(top_row_reg);
    assign bottom_w = COLOR_W'(bottom_row_reg);

    // next state of the sequencer
    always_comb begin
        phase_next      = phase_reg;
        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        left_col_next   = left_col_reg;
        right_col_next  = right_col_reg;
        top_row_next    = top_row_reg;
        bottom_row_next = bottom_row_reg;
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        held_rr_next    = held_rr_reg;
        held_color_next = held_color_reg;

        if (fire && is_start) begin
            // a start drops any circle in progress
            phase_next      = PH_COLSET;
            left_col_next   = win_left[COL_W-1:0];
            right_col_next  = win_right[COL_W-1:0];
            top_row_next    = win_top;
            bottom_row_next = win_bottom;
            scan_col_next   = win_left[COL_W-1:0];
            scan_row_next   = win_top;
            held_cx_next    = in_cx_reg;
            held_cy_next    = in_cy_reg;
            held_rr_next    = RR_W'(in_radius_reg) * RR_W'(in_radius_reg);
            held_color_next = in_color_reg;
        end else if (produce) begin
            unique case (phase_reg)
                PH_COLSET: phase_next = PH_COL_LH;
                PH_COL_LH: phase_next = PH_COL_LL;
                PH_COL_LL: phase_next = PH_COL_RH;
                PH_COL_RH: phase_next = PH_COL_RL;
                PH_COL_RL: phase_next = PH_ROWSET;
                PH_ROWSET: phase_next = PH_ROW_TH;
                PH_ROW_TH: phase_next = PH_ROW_TL;
                PH_ROW_TL: phase_next = PH_ROW_BH;
                PH_ROW_BH: phase_next = PH_ROW_BL;
                PH_ROW_BL: phase_next = PH_RAMWR;
                PH_RAMWR:  phase_next = PH_PIXEL;
                PH_PIXEL: begin
                    // column-major scan, rows inner
                    if (row_end) begin
                        scan_row_next = top_row_reg;
                        if (col_end) begin
                            phase_next = PH_IDLE;
                        end else begin
                            scan_col_next = scan_col_reg + 1'b1;
                        end
                    end else begin
                        scan_row_next = scan_row_reg + 1'b1;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // word for the current phase
    always_comb begin
        word_kind  = KIND_DATA;
        word_value = '0;
        word_last  = 1'b0;
        unique case (phase_reg)
            PH_COLSET: word_kind  = KIND_COLSET;
            PH_COL_LH: word_value = {8'h00, left_w[15:8]};
            PH_COL_LL: word_value = {8'h00, left_w[7:0]};
            PH_COL_RH: word_value = {8'h00, right_w[15:8]};
            PH_COL_RL: word_value = {8'h00, right_w[7:0]};
            PH_ROWSET: word_kind  = KIND_ROWSET;
            PH_ROW_TH: word_value = {8'h00, top_w[15:8]};
            PH_ROW_TL: word_value = {8'h00, top_w[7:0]};
            PH_ROW_BH: word_value = {8'h00, bottom_w[15:8]};
            PH_ROW_BL: word_value = {8'h00, bottom_w[7:0]};
            PH_RAMWR:  word_kind  = KIND_RAMWR;
            PH_PIXEL: begin
                word_value = in_circle ? held_color_reg : bg_color_reg;
                word_last  = row_end && col_end;
            end
            default: word_kind = KIND_DATA;
        endcase
    end

    // result register keeps its word until taken
    assign m_valid_next = out_free ? produce : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_color_reg <= BG_COLOR_RESET;
        end else if (cfg_wr_en) begin
            bg_color_reg <= cfg_wr_data;
        end
    end

    // input register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg     <= op_t'(s_tuser);
            in_cx_reg     <= s_tdata[COL_W-1:0];
            in_cy_reg     <= s_tdata[COL_W +: ROW_W];
            in_radius_reg <= s_tdata[COL_W+ROW_W +: RAD_W];
            in_color_reg  <= s_tdata[COL_W+ROW_W+RAD_W +: COLOR_W];
        end
    end

    // sequencer and held circle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            left_col_reg   <= '0;
            right_col_reg  <= '0;
            top_row_reg    <= '0;
            bottom_row_reg <= '0;
            held_cx_reg    <= '0;
            held_cy_reg    <= '0;
            held_rr_reg    <= '0;
            held_color_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
            left_col_reg   <= left_col_next;
            right_col_reg  <= right_col_next;
            top_row_reg    <= top_row_next;
            bottom_row_reg <= bottom_row_next;
            held_cx_reg    <= held_cx_next;
            held_cy_reg    <= held_cy_next;
            held_rr_reg    <= held_rr_next;
            held_color_reg <= held_color_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_kind_reg  <= word_kind;
            m_value_reg <= word_value;
            m_last_reg  <= word_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_value_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: tb/filled_circle_pixel_stream_tb.sv
// ----------------------------------------------------------------------------
// filled_circle_pixel_stream_tb
// self-checking bench for the circle rasterizer: circle requests with edge and
// off-screen centers, finished and abandoned circles, random stalls on both
// channels and a long hold on the word side, every word compared by field
// against a transaction-level copy of the window setup and column-major scan
// ----------------------------------------------------------------------------
module filled_circle_pixel_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcps_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 11;
    localparam int PHASE_COUNT    = 5;
    localparam int PHASE_REQUESTS = 280;   // productive requests per background setting
    localparam int HOLD_AT_WORD   = 400;   // word count at which the sink goes quiet
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;     // margin after the last expected word
    localparam int IDLE_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int REPORT_LIMIT   = 10;
    localparam int HEADER_WORDS   = PH_PIXEL - PH_COLSET;
    localparam int LONG_CUT       = 40;    // most advances sent into an abandoned circle

    // request payload, highest field first
    typedef struct packed {
        logic [COLOR_W-1:0] fill;
        logic [RAD_W-1:0]   radius;
        logic [ROW_W-1:0]   center_y;
        logic [COL_W-1:0]   center_x;
    } circle_fields_t;

    typedef struct packed {
        kind_t              kind;
        logic [COLOR_W-1:0] value;
        logic               last;
    } bus_word_t;

    // ------------------------------------------------------------------------
    // expected word stream: window setup and pixel scan kept at request level
    // ------------------------------------------------------------------------
    class pixel_word_scoreboard;
        logic [COLOR_W-1:0] background;
        phase_t             position;
        circle_fields_t     circle;
        logic [COL_W-1:0]   left_col, right_col, scan_col;
        logic [ROW_W-1:0]   top_row, bottom_row, scan_row;
        bus_word_t          expected_words[$];
        int                 errors;

        function new();
            background = BG_COLOR_RESET;
            position   = PH_IDLE;
            circle     = '0;
            left_col   = '0;
            right_col  = '0;
            scan_col   = '0;
            top_row    = '0;
            bottom_row = '0;
            scan_row   = '0;
            errors     = 0;
        endfunction

        // bounding span on one axis, clamped into 0..limit-1
        static function void clamp_span(input int center, input int radius, input int limit,
                                        output int lo, output int hi);
            lo = center - radius;
            hi = center + radius;
            if (lo < 0) lo = 0;
            if (lo > limit - 1) lo = limit - 1;
            if (hi < 0) hi = 0;
            if (hi > limit - 1) hi = limit - 1;
            if (lo > hi) lo = hi;
        endfunction

        // header plus one word per window pixel
        static function int circle_words(input circle_fields_t c);
            int lo_x, hi_x, lo_y, hi_y;
            clamp_span(int'(c.center_x), int'(c.radius), SCREEN_WIDTH, lo_x, hi_x);
            clamp_span(int'(c.center_y), int'(c.radius), SCREEN_HEIGHT, lo_y, hi_y);
            return HEADER_WORDS + (hi_x - lo_x + 1) * (hi_y - lo_y + 1);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_request(input op_t op, input circle_fields_t c);
            bus_word_t w;
            int        lo, hi, dx, dy;
            if (op == OP_START) begin
                // a start replaces whatever circle was in progress
                circle = c;
                clamp_span(int'(c.center_x), int'(c.radius), SCREEN_WIDTH, lo, hi);
                left_col  = COL_W'(lo);
                right_col = COL_W'(hi);
                clamp_span(int'(c.center_y), int'(c.radius), SCREEN_HEIGHT, lo, hi);
                top_row    = ROW_W'(lo);
                bottom_row = ROW_W'(hi);
                scan_col   = left_col;
                scan_row   = top_row;
                position   = PH_COLSET;
                return;
            end
            if (position == PH_IDLE)
                return;
            w.kind  = KIND_DATA;
            w.value = '0;
            w.last  = 1'b0;
            case (position)
                PH_COLSET: w.kind  = KIND_COLSET;
                PH_COL_LH: w.value = COLOR_W'(left_col >> 8);
                PH_COL_LL: w.value = COLOR_W'(left_col[7:0]);
                PH_COL_RH: w.value = COLOR_W'(right_col >> 8);
                PH_COL_RL: w.value = COLOR_W'(right_col[7:0]);
                PH_ROWSET: w.kind  = KIND_ROWSET;
                PH_ROW_TH: w.value = COLOR_W'(top_row >> 8);
                PH_ROW_TL: w.value = COLOR_W'(top_row[7:0]);
                PH_ROW_BH: w.value = COLOR_W'(bottom_row >> 8);
                PH_ROW_BL: w.value = COLOR_W'(bottom_row[7:0]);
                PH_RAMWR:  w.kind  = KIND_RAMWR;
                default: begin
                    dx = int'(scan_col) - int'(circle.center_x);
                    dy = int'(scan_row) - int'(circle.center_y);
                    w.value = (dx * dx + dy * dy < int'(circle.radius) * int'(circle.radius))
                              ? circle.fill : background;
                    // rows inside columns, both bounds inclusive
                    if (scan_row >= bottom_row) begin
                        scan_row = top_row;
                        if (scan_col >= right_col) begin
                            w.last   = 1'b1;
                            position = PH_IDLE;
                        end else begin
                            scan_col = scan_col + 1'b1;
                        end
                    end else begin
                        scan_row = scan_row + 1'b1;
                    end
                end
            endcase
            if (position != PH_IDLE && position != PH_PIXEL)
                position = phase_t'(position + 1);
            expected_words.push_back(w);
        endfunction

        function void check_word(input kind_t kind, input logic [COLOR_W-1:0] value,
                                 input logic last);
            bus_word_t want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: word with nothing expected: kind %0d value %h last %b",
                             $time, kind, value, last);
                return;
            end
            want = expected_words.pop_front();
            if (kind !== want.kind || value !== want.value || last !== want.last) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: word mismatch: expected kind %0d value %h last %b, got kind %0d value %h last %b",
                             $time, want.kind, want.value, want.last, kind, value, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [COLOR_W-1:0]   m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [COLOR_W-1:0]   cfg_wr_data;

    // per-side switches for random idling, changed between phases
    bit send_idle = 1'b1;
    bit take_idle = 1'b1;

    pixel_word_scoreboard word_check = new();

    always #HALF_PERIOD aclk = ~aclk;

    filled_circle_pixel_stream i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // center_x, center_y, radius, fill_color, zero fill
        .s_tuser     (s_tuser),      // operation
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // word_value
        .m_tuser     (m_tuser),      // word_kind
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // monitor: values seen here are the ones from before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            // check before noting: a request never yields a word on its own edge
            if (m_tvalid && m_tready)
                word_check.check_word(kind_t'(m_tuser), m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                word_check.note_request(op_t'(s_tuser),
                                        circle_fields_t'(s_tdata[$bits(circle_fields_t)-1:0]));
            // register writes happen only while idle, so the order here is free
            if (cfg_wr_en)
                word_check.background = cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------

    // offer one request after a random gap and return on its handshake edge
    task automatic send_request(input op_t op, input circle_fields_t fields);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'(fields);
        do @(posedge aclk); while (!s_tready);
    endtask

    // start a circle and push a number of advances into it; the unused
    // advance payload is random so every request bit toggles
    task automatic send_circle(input circle_fields_t circle, input int advances);
        circle_fields_t noise;
        send_request(OP_START, circle);
        for (int i = 0; i < advances; i++) begin
            noise.center_x = COL_W'($urandom);
            noise.center_y = ROW_W'($urandom);
            noise.radius   = RAD_W'($urandom);
            noise.fill     = COLOR_W'($urandom);
            send_request(OP_ADVANCE, noise);
        end
    endtask

    // one random circle: mostly small and run to the last pixel, sometimes
    // cut short so the next start abandons it
    task automatic random_circle(output int requests);
        circle_fields_t c;
        int             words, advances, pick;
        case ($urandom_range(0, 3))
            0:       c.center_x = COL_W'($urandom_range(0, 3));
            1:       c.center_x = COL_W'($urandom_range(SCREEN_WIDTH - 4, 2**COL_W - 1));
            default: c.center_x = COL_W'($urandom);
        endcase
        // rows past the screen are common, the field reaches 511
        case ($urandom_range(0, 3))
            0:       c.center_y = ROW_W'($urandom_range(0, 3));
            1:       c.center_y = ROW_W'($urandom_range(SCREEN_HEIGHT - 4, 2**ROW_W - 1));
            default: c.center_y = ROW_W'($urandom);
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 14)
            c.radius = RAD_W'($urandom_range(0, 3));
        else if (pick < 18)
            c.radius = RAD_W'($urandom_range(4, 7));
        else
            c.radius = RAD_W'($urandom);
        c.fill = COLOR_W'($urandom);

        words = pixel_word_scoreboard::circle_words(c);
        if (words <= 300 && $urandom_range(0, 3) != 0)
            advances = words;
        else
            advances = $urandom_range(0, (words - 1 < LONG_CUT) ? words - 1 : LONG_CUT);
        send_circle(c, advances);
        requests = 1 + advances;

        // stray advances after a finished circle, ignored by the block
        if (advances == words && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_request(OP_ADVANCE, c);
    endtask

    // stop offering and wait for every expected word, plus pipeline drain
    task automatic drain_words();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (word_check.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_background(input logic [COLOR_W-1:0] shade);
        drain_words();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= shade;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        circle_fields_t     c;
        int                 requests, taken;
        logic [COLOR_W-1:0] shade;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_START;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, background still at its reset value

        // advance with no circle started: no word
        c = '1;
        send_request(OP_ADVANCE, c);
        // zero radius at the origin: single pixel, nothing is closer than zero,
        // so it comes out in the background color with the last mark
        c = '0;
        send_circle(c, pixel_word_scoreboard::circle_words(c));
        // center past both screen edges with the widest radius: window clamps
        // to the whole screen; header and first pixel only, the next start
        // throws it away
        c = '1;
        send_circle(c, HEADER_WORDS + 1);

        // random part, one background setting per phase, extremes first
        for (int p = 0; p < PHASE_COUNT; p++) begin
            send_idle = (p != 1);   // phase 1 floods the request side
            take_idle = (p != 2);   // phase 2 keeps the word side always ready
            case (p)
                0:       shade = '0;
                1:       shade = '1;
                default: shade = COLOR_W'($urandom);
            endcase
            write_background(shade);
            taken = 0;
            while (taken < PHASE_REQUESTS) begin
                random_circle(requests);
                taken += requests;
            end
        end

        drain_words();
        if (word_check.errors == 0 && word_check.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // word sink: random back-pressure, one long hold to fill the pipeline
    // ------------------------------------------------------------------------
    initial begin : word_sink
        int gap, words_seen;
        words_seen = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (words_seen == HOLD_AT_WORD)
                gap = HOLD_CYCLES;
            else
                gap = take_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            words_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends a run that stops making progress
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
src/fcps_pkg.sv
src/fcps_span_clamp.sv
src/fcps_pixel_test.sv
src/filled_circle_pixel_stream.sv
tb/filled_circle_pixel_stream_tb.sv
